FILE: rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// phase and status codes, register indexes, the measurement record passed
// from the front to the back, and the constants of the distance scaling
// ----------------------------------------------------------------------------
package uer_pkg;

	// default width of the stamp counter, which advances on every accepted tick
	localparam int STAMP_BITS_DEF = 16;

	// widths of the configuration registers and of the phase counter
	localparam int TRIG_BITS  = 8;
	localparam int WAIT_BITS  = 16;
	localparam int RANGE_BITS = 10;
	localparam int CNT_BITS   = 16;
	localparam int CFG_BITS   = 16;
	localparam int IDX_BITS   = 2;

	// register reset values
	localparam logic [TRIG_BITS-1:0]  TRIG_WIDTH_RST   = 8'd15;
	localparam logic [WAIT_BITS-1:0]  WAIT_LIMIT_RST   = 16'd40000;
	localparam logic [RANGE_BITS-1:0] MAX_RANGE_RST    = 10'd500;

	// register indexes
	localparam logic [IDX_BITS-1:0] REG_TRIG_WIDTH = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_WAIT_LIMIT = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_MAX_RANGE  = 2'd2;

	// duration bits; a 16-bit duration gives a distance of at most 1114 cm
	localparam int DUR_BITS = 16;

	// distance = floor(dur * 17 / 1000) = (dur * DIST_RECIP) >> DIST_SHIFT
	// exact for every 16-bit duration since dur * 312 < 2^26
	localparam int RECIP_BITS = 21;
	localparam logic [RECIP_BITS-1:0] DIST_RECIP = 21'd1140851;
	localparam int DIST_SHIFT = 26;
	localparam int PROD_BITS  = DUR_BITS + RECIP_BITS;
	localparam int DIST_BITS  = PROD_BITS - DIST_SHIFT;
	localparam int DIST_OUT_BITS = 9;
	localparam logic [DIST_BITS-1:0] DIST_FIELD_MAX = 11'd511;

	// decoupling queue
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TRIG = 2'd1,
		PH_WAIT = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	// one tick as classified by the front
	typedef struct packed {
		logic                trig;
		logic                busy;
		logic                done;
		logic                timeout;
		logic                over;
		logic [DUR_BITS-1:0] dur;
	} meas_t;

endpackage

FILE: rtl/uer_front.sv
// ----------------------------------------------------------------------------
// uer_front: tick sequencer
// runs the idle / trigger / wait phases, the stamp counter and echo edge
// capture, and classifies each accepted tick into a measurement record
// ----------------------------------------------------------------------------
module uer_front #(
	parameter int STAMP_BITS = uer_pkg::STAMP_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic                            start_req,
	input  logic                            echo_level,
	input  logic [uer_pkg::TRIG_BITS-1:0]   trig_width,
	input  logic [uer_pkg::WAIT_BITS-1:0]   wait_limit,
	output uer_pkg::meas_t                  item
);

	uer_pkg::phase_t                 phase_q, phase_n;
	logic [uer_pkg::CNT_BITS-1:0]    cnt_q, cnt_n;
	logic [STAMP_BITS-1:0]           stamp_q;
	logic [STAMP_BITS-1:0]           rise_q, rise_n;
	logic [STAMP_BITS-1:0]           fall_q, fall_n;
	logic                            prev_echo_q;
	logic                            captured_q, captured_n;
	logic                            trig, done, timeout;
	logic [STAMP_BITS-1:0]           dur;
	logic [uer_pkg::DUR_BITS-1:0]    dur_lo;
	logic                            over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= uer_pkg::PH_IDLE;
			cnt_q       <= '0;
			stamp_q     <= '0;
			rise_q      <= '0;
			fall_q      <= '0;
			prev_echo_q <= 1'b0;
			captured_q  <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_n;
			cnt_q       <= cnt_n;
			stamp_q     <= stamp_q + 1'b1;
			rise_q      <= rise_n;
			fall_q      <= fall_n;
			prev_echo_q <= echo_level;
			captured_q  <= captured_n;
		end
	end

	always_comb begin
		phase_n    = phase_q;
		cnt_n      = cnt_q;
		captured_n = captured_q;
		rise_n     = rise_q;
		fall_n     = fall_q;
		trig       = 1'b0;
		done       = 1'b0;
		timeout    = 1'b0;

		case (phase_q)
			uer_pkg::PH_TRIG: begin
				if (cnt_q < uer_pkg::CNT_BITS'(trig_width)) begin
					trig  = 1'b1;
					cnt_n = cnt_q + 1'b1;
				end else begin
					phase_n = uer_pkg::PH_WAIT;
					cnt_n   = '0;
				end
			end
			uer_pkg::PH_WAIT: begin
			end
			default: begin
				phase_n = uer_pkg::PH_IDLE;
				if (start_req) begin
					captured_n = 1'b0;
					phase_n    = uer_pkg::PH_TRIG;
					cnt_n      = uer_pkg::CNT_BITS'(1);
					trig       = 1'b1;
				end
			end
		endcase

		// echo edges are seen in every phase
		if (echo_level && !prev_echo_q) begin
			rise_n = stamp_q;
		end else if (!echo_level && prev_echo_q) begin
			fall_n     = stamp_q;
			captured_n = 1'b1;
		end

		// wait phase, also on the tick that enters it
		if (phase_n == uer_pkg::PH_WAIT) begin
			if (captured_n) begin
				done    = 1'b1;
				phase_n = uer_pkg::PH_IDLE;
				cnt_n   = '0;
			end else if (cnt_n >= wait_limit) begin
				done    = 1'b1;
				timeout = 1'b1;
				phase_n = uer_pkg::PH_IDLE;
				cnt_n   = '0;
			end else begin
				cnt_n = cnt_n + 1'b1;
			end
		end
	end

	assign dur = fall_n - rise_n;

	generate
		if (STAMP_BITS > uer_pkg::DUR_BITS) begin : g_wide
			assign over   = |dur[STAMP_BITS-1:uer_pkg::DUR_BITS];
			assign dur_lo = dur[uer_pkg::DUR_BITS-1:0];
		end else begin : g_narrow
			assign over   = 1'b0;
			assign dur_lo = uer_pkg::DUR_BITS'(dur);
		end
	endgenerate

	always_comb begin
		item.trig    = trig;
		item.busy    = (phase_n != uer_pkg::PH_IDLE);
		item.done    = done;
		item.timeout = timeout;
		item.over    = over;
		item.dur     = dur_lo;
	end

	// a finished measurement always returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.done |=> phase_q == uer_pkg::PH_IDLE)
		else $error("phase not idle after a finished measurement");

	// trigger drive only while a measurement is under way
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item.trig |-> item.busy && !item.done)
		else $error("trigger driven outside the trigger phase");

endmodule

FILE: rtl/uer_queue.sv
// ----------------------------------------------------------------------------
// uer_queue: short queue of measurement records
// sits between the sequencer and the distance pipeline
// ----------------------------------------------------------------------------
module uer_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  uer_pkg::meas_t  push_data,
	input  logic            pop,
	output uer_pkg::meas_t  pop_data,
	output logic            full,
	output logic            empty
);

	localparam int PTR_BITS = $clog2(uer_pkg::QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(uer_pkg::QUEUE_DEPTH + 1);

	uer_pkg::meas_t        mem_q [uer_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0]   count_q;

	assign full     = (count_q == CNT_BITS'(uer_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(uer_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(uer_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from an empty queue");

endmodule

FILE: rtl/uer_back.sv
// ----------------------------------------------------------------------------
// uer_back: distance pipeline and result register
// scales the echo duration to centimeters, checks the range and holds
// the result for the output channel
// ----------------------------------------------------------------------------
module uer_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	input  uer_pkg::meas_t                  q_data,
	output logic                            pop,
	input  logic [uer_pkg::RANGE_BITS-1:0]  max_range_cm,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            trig_out,
	output logic                            busy_res,
	output logic                            done_res,
	output logic [1:0]                      status,
	output logic [uer_pkg::DIST_OUT_BITS-1:0] distance_cm
);

	logic                              s1_rdy, out_rdy;
	logic                              valid_s1;
	logic [uer_pkg::PROD_BITS-1:0]     prod_s1;
	logic                              trig_s1, busy_s1, done_s1, timeout_s1, over_s1;
	logic [uer_pkg::DIST_BITS-1:0]     dist_calc;
	uer_pkg::status_t                  st;
	logic [uer_pkg::DIST_OUT_BITS-1:0] dist_res;
	logic                              out_valid_q;
	logic                              trig_q, busy_q, done_q;
	uer_pkg::status_t                  status_q;
	logic [uer_pkg::DIST_OUT_BITS-1:0] dist_q;

	assign out_rdy = !out_valid_q || !out_stall;
	assign s1_rdy  = !valid_s1 || out_rdy;
	assign pop     = !q_empty && s1_rdy;

	// stage 1: multiply by the reciprocal of 1000/17
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_rdy) begin
			valid_s1 <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1    <= uer_pkg::PROD_BITS'(q_data.dur) *
				uer_pkg::PROD_BITS'(uer_pkg::DIST_RECIP);
			trig_s1    <= q_data.trig;
			busy_s1    <= q_data.busy;
			done_s1    <= q_data.done;
			timeout_s1 <= q_data.timeout;
			over_s1    <= q_data.over;
		end
	end

	// stage 2: range check and field cleanup
	assign dist_calc = prod_s1[uer_pkg::DIST_SHIFT +: uer_pkg::DIST_BITS];

	always_comb begin
		st       = uer_pkg::ST_OK;
		dist_res = '0;
		if (done_s1) begin
			if (timeout_s1) begin
				st = uer_pkg::ST_TIMEOUT;
			end else if (over_s1 || dist_calc == '0 ||
				dist_calc > uer_pkg::DIST_BITS'(max_range_cm) ||
				dist_calc > uer_pkg::DIST_FIELD_MAX) begin
				st = uer_pkg::ST_RANGE;
			end else begin
				dist_res = dist_calc[uer_pkg::DIST_OUT_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_rdy) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && valid_s1) begin
			trig_q   <= trig_s1;
			busy_q   <= busy_s1;
			done_q   <= done_s1;
			status_q <= st;
			dist_q   <= dist_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign trig_out    = trig_q;
	assign busy_res    = busy_q;
	assign done_res    = done_q;
	assign status      = status_q;
	assign distance_cm = dist_q;

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !done_q |-> status_q == uer_pkg::ST_OK && dist_q == '0)
		else $error("status or distance set on a tick without a result");

	a_err_no_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != uer_pkg::ST_OK |-> dist_q == '0)
		else $error("distance reported with an error status");

endmodule

FILE: rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: trigger / echo-time distance meter
// one request per microsecond tick; drives the trigger pulse, times the
// echo pulse and reports distance in centimeters or an error status
//
//   channel  | signals                                         | direction
//   ---------+-------------------------------------------------+----------
//   in       | in_valid, in_stall, start_req, echo_level       | request in
//   out      | out_valid, out_stall, trig_out, busy_res,       | request out
//            | done_res, status, distance_cm                   |
//   cfg      | cfg_wr_en, cfg_index, cfg_data                  | write only
//
// one request per clock while in_stall stays low; every request gives exactly one result
// a request passes from acceptance to out_valid through these registered
// steps:
//   sequencer -> queue -> multiply stage -> result register
// the sequencer takes a request whenever the four-entry queue has room, so
// an output stall is absorbed by the queue and the pipeline before in_stall
// rises; asynchronous reset clears all phases, counters and edge history
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
	parameter int STAMP_BITS = uer_pkg::STAMP_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request in
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              start_req,
	input  logic                              echo_level,
	// result out
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              trig_out,
	output logic                              busy_res,
	output logic                              done_res,
	output logic [1:0]                        status,
	output logic [uer_pkg::DIST_OUT_BITS-1:0] distance_cm,
	// configuration writes
	input  logic                              cfg_wr_en,
	input  logic [uer_pkg::IDX_BITS-1:0]      cfg_index,
	input  logic [uer_pkg::CFG_BITS-1:0]      cfg_data
);

	logic [uer_pkg::TRIG_BITS-1:0]  trig_width_q;
	logic [uer_pkg::WAIT_BITS-1:0]  wait_limit_q;
	logic [uer_pkg::RANGE_BITS-1:0] max_range_q;

	logic           accept;
	uer_pkg::meas_t item;
	uer_pkg::meas_t q_data;
	logic           q_full, q_empty, q_pop;

	// configuration registers; index three is not decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_width_q <= uer_pkg::TRIG_WIDTH_RST;
			wait_limit_q <= uer_pkg::WAIT_LIMIT_RST;
			max_range_q  <= uer_pkg::MAX_RANGE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				uer_pkg::REG_TRIG_WIDTH: trig_width_q <= cfg_data[uer_pkg::TRIG_BITS-1:0];
				uer_pkg::REG_WAIT_LIMIT: wait_limit_q <= cfg_data[uer_pkg::WAIT_BITS-1:0];
				uer_pkg::REG_MAX_RANGE:  max_range_q  <= cfg_data[uer_pkg::RANGE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// the queue only pushes back when all four entries are taken
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// front: phase sequencing, stamps and edge capture
	uer_front #(
		.STAMP_BITS (STAMP_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.start_req  (start_req),
		.echo_level (echo_level),
		.trig_width (trig_width_q),
		.wait_limit (wait_limit_q),
		.item       (item)
	);

	// decoupling between tick classification and distance math
	uer_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (item),
		.pop       (q_pop),
		.pop_data  (q_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	// back: distance scaling, range check, result register
	uer_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_data),
		.pop          (q_pop),
		.max_range_cm (max_range_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.trig_out     (trig_out),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.status       (status),
		.distance_cm  (distance_cm)
	);

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ultrasonic echo ranger
// feeds microsecond ticks (start request, echo level) through the request
// channel and tracks the trigger, wait, echo capture and range check in a
// cycle-free model of its own; every result request is checked field by field
// against the oldest pending reading while both sides idle and stall at random
// ----------------------------------------------------------------------------
module tb;
	import uer_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 5_000_000;
	localparam int unsigned TAIL_CYCLES  = 16;
	localparam int unsigned ITEM_TARGET  = 1350;
	localparam int unsigned RUNS_PER_SET = 3;

	// one expected or observed result request
	typedef struct packed {
		logic                     trig;
		logic                     busy;
		logic                     done;
		status_t                  code;
		logic [DIST_OUT_BITS-1:0] dist_cm;
	} reading_t;

	// tick-accurate tracker of the ranger and store of pending readings
	class range_tracker;
		logic [TRIG_BITS-1:0]      trig_width;
		logic [WAIT_BITS-1:0]      wait_limit;
		logic [RANGE_BITS-1:0]     max_range;
		phase_t                    phase;
		logic [CNT_BITS-1:0]       phase_count;
		logic [STAMP_BITS_DEF-1:0] stamp;
		logic [STAMP_BITS_DEF-1:0] rise_stamp;
		logic [STAMP_BITS_DEF-1:0] fall_stamp;
		logic                      prev_echo;
		logic                      captured;
		reading_t                  pending_readings[$];
		int unsigned               mismatches;

		function new();
			trig_width  = TRIG_WIDTH_RST;
			wait_limit  = WAIT_LIMIT_RST;
			max_range   = MAX_RANGE_RST;
			phase       = PH_IDLE;
			phase_count = '0;
			stamp       = '0;
			rise_stamp  = '0;
			fall_stamp  = '0;
			prev_echo   = 1'b0;
			captured    = 1'b0;
			mismatches  = 0;
		endfunction

		function bit busy();
			return phase != PH_IDLE;
		endfunction

		function void write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
			case (idx)
				REG_TRIG_WIDTH: trig_width = val[TRIG_BITS-1:0];
				REG_WAIT_LIMIT: wait_limit = val[WAIT_BITS-1:0];
				REG_MAX_RANGE:  max_range  = val[RANGE_BITS-1:0];
				default: ;
			endcase
		endfunction

		// advance one tick and queue the reading it produces
		function void take_tick(logic start, logic echo);
			reading_t                  r;
			logic [STAMP_BITS_DEF-1:0] dur;
			int                        dist_val;
			r = '{trig: 1'b0, busy: 1'b0, done: 1'b0, code: ST_OK, dist_cm: '0};
			if (phase == PH_TRIG) begin
				if (phase_count < CNT_BITS'(trig_width)) begin
					r.trig = 1'b1;
					phase_count++;
				end else begin
					phase = PH_WAIT;
					phase_count = '0;
				end
			end else if (phase != PH_WAIT) begin
				phase = PH_IDLE;
				if (start) begin
					captured = 1'b0;
					phase = PH_TRIG;
					phase_count = CNT_BITS'(1);
					r.trig = 1'b1;
				end
			end
			if (echo && !prev_echo)
				rise_stamp = stamp;
			else if (!echo && prev_echo) begin
				fall_stamp = stamp;
				captured = 1'b1;
			end
			prev_echo = echo;
			if (phase == PH_WAIT) begin
				if (captured) begin
					dur = fall_stamp - rise_stamp;
					dist_val = (int'(dur) * 17) / 1000;
					r.done = 1'b1;
					if (dist_val == 0 || dist_val > int'(max_range) ||
						dist_val > int'(DIST_FIELD_MAX))
						r.code = ST_RANGE;
					else
						r.dist_cm = dist_val[DIST_OUT_BITS-1:0];
					phase = PH_IDLE;
					phase_count = '0;
				end else if (phase_count >= wait_limit) begin
					r.done = 1'b1;
					r.code = ST_TIMEOUT;
					phase = PH_IDLE;
					phase_count = '0;
				end else
					phase_count++;
			end
			stamp++;
			r.busy = (phase != PH_IDLE);
			pending_readings.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void match_result(reading_t got);
			reading_t want;
			if (pending_readings.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected result, expected none, got %p", $time, got);
				return;
			end
			want = pending_readings.pop_front();
			compare_field("trig_out", want.trig, got.trig);
			compare_field("busy_res", want.busy, got.busy);
			compare_field("done_res", want.done, got.done);
			compare_field("status", want.code, got.code);
			compare_field("distance_cm", want.dist_cm, got.dist_cm);
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     start_req = 1'b0;
	logic                     echo_level = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     trig_out;
	logic                     busy_res;
	logic                     done_res;
	logic [1:0]               status;
	logic [DIST_OUT_BITS-1:0] distance_cm;
	logic                     cfg_wr_en = 1'b0;
	logic [IDX_BITS-1:0]      cfg_index = '0;
	logic [CFG_BITS-1:0]      cfg_data = '0;

	range_tracker tracker;
	// idling switches of the request side and the result side
	bit           src_idle = 1'b0;
	bit           sink_idle = 1'b0;
	int unsigned  ticks_sent = 0;
	int unsigned  cycle_count = 0;

	ultrasonic_echo_ranger i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.start_req   (start_req),
		.echo_level  (echo_level),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.trig_out    (trig_out),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.status      (status),
		.distance_cm (distance_cm),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle cycles before the next request on one side, none when idling is off
	function automatic int unsigned draw_gap(bit enabled);
		return enabled ? $urandom_range(0, 16) : 0;
	endfunction

	// start requests while busy must be ignored, so chatter on them freely
	function automatic logic busy_start();
		return tracker.busy() ? 1'($urandom_range(0, 1)) : 1'b0;
	endfunction

	// one tick request; entered and left at a falling edge, valid kept high
	// on return so back-to-back requests never lower and raise it in one step
	task automatic send_tick(input logic start, input logic echo);
		int unsigned gap;
		gap = draw_gap(src_idle);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		start_req <= start;
		echo_level <= echo;
		do @(posedge clk); while (in_stall);
		tracker.take_tick(start, echo);
		ticks_sent++;
		@(negedge clk);
	endtask

	// finish any measurement, let every pending reading come back, then
	// give the pipeline its latency before touching the registers
	task automatic settle();
		while (tracker.busy())
			send_tick(1'b0, 1'b0);
		in_valid <= 1'b0;
		while (tracker.pending_readings.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// write all three registers on consecutive cycles with the enable held
	task automatic write_regs(input logic [TRIG_BITS-1:0] tw, input logic [WAIT_BITS-1:0] wl,
			input logic [RANGE_BITS-1:0] mr);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_TRIG_WIDTH;
		cfg_data <= CFG_BITS'(tw);
		@(negedge clk);
		cfg_index <= REG_WAIT_LIMIT;
		cfg_data <= CFG_BITS'(wl);
		@(negedge clk);
		cfg_index <= REG_MAX_RANGE;
		cfg_data <= CFG_BITS'(mr);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tracker.write_reg(REG_TRIG_WIDTH, CFG_BITS'(tw));
		tracker.write_reg(REG_WAIT_LIMIT, CFG_BITS'(wl));
		tracker.write_reg(REG_MAX_RANGE, CFG_BITS'(mr));
	endtask

	// one measurement: echo high for pre_high idle ticks before the start
	// (a stale pulse), lead ticks of low echo after the start, then an echo
	// pulse of width ticks, then low echo until the ranger goes idle
	task automatic run_pulse(input int unsigned pre_high, input int unsigned lead,
			input int unsigned width);
		while (tracker.busy())
			send_tick(1'b1, 1'b0);
		repeat (pre_high) send_tick(1'b0, 1'b1);
		send_tick(1'b1, pre_high != 0);
		repeat (lead) send_tick(busy_start(), 1'b0);
		repeat (width) send_tick(busy_start(), 1'b1);
		send_tick(busy_start(), 1'b0);
		while (tracker.busy())
			send_tick(1'b1, 1'b0);
	endtask

	// result side: stall for a drawn number of cycles, then take one result
	initial begin : result_sink
		int unsigned gap;
		reading_t    got;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(sink_idle);
			@(negedge clk);
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			got = '{trig: trig_out, busy: busy_res, done: done_res,
				code: status_t'(status), dist_cm: distance_cm};
			tracker.match_result(got);
		end
	end

	// generous bound on the whole run
	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		int unsigned runs;
		int unsigned pick;
		int unsigned width;
		logic [TRIG_BITS-1:0]  tw;
		logic [WAIT_BITS-1:0]  wl;
		logic [RANGE_BITS-1:0] mr;

		tracker = new();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed, at the reset register values ---
		// echo already high at the start, falls inside the trigger pulse:
		// the stale capture ends the wait at once with a zero distance
		run_pulse(2, 1, 0);
		// short clean echo, about one centimeter
		run_pulse(0, 20, 100);
		settle();

		// zero trigger width acts as one, zero wait limit times out at once
		write_regs(8'd0, 16'd0, 10'd1000);
		run_pulse(0, 0, 0);
		run_pulse(3, 0, 0);
		run_pulse(0, 2, 0);
		settle();

		// one centimeter range: last accepted echo, one past it, a zero
		// distance, then a full-length timeout
		write_regs(8'd20, 16'd150, 10'd1);
		run_pulse(0, 5, 117);
		run_pulse(0, 5, 118);
		run_pulse(0, 0, 58);
		run_pulse(0, 0, 0);
		settle();

		// --- random: register sets, each with a few measurements ---
		while (ticks_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			tw = (pick < 5) ? TRIG_BITS'($urandom_range(1, 6)) :
				(pick < 9) ? TRIG_BITS'($urandom_range(7, 40)) :
				TRIG_BITS'($urandom_range(200, 255));
			pick = $urandom_range(0, 9);
			wl = (pick < 7) ? WAIT_BITS'($urandom_range(20, 150)) :
				(pick < 9) ? WAIT_BITS'($urandom_range(1, 19)) :
				WAIT_BITS'($urandom_range(151, 400));
			mr = ($urandom_range(0, 1) != 0) ? RANGE_BITS'($urandom_range(1, 6)) :
				RANGE_BITS'($urandom_range(7, 1000));
			write_regs(tw, wl, mr);
			// some sets run with no idling at all on one or both sides
			src_idle = ($urandom_range(0, 2) != 0);
			sink_idle = ($urandom_range(0, 2) != 0);
			runs = 0;
			while (runs < RUNS_PER_SET && ticks_sent < ITEM_TARGET) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					// well-formed echo, mostly a few centimeters
					width = $urandom_range(0, 9);
					width = (width < 7) ? $urandom_range(59, 150) :
						(width < 9) ? $urandom_range(1, 58) : $urandom_range(151, 300);
					run_pulse(0, $urandom_range(0, 30), width);
				end else if (pick < 75)
					// no echo at all
					run_pulse(0, $urandom_range(0, 30), 0);
				else if (pick < 88)
					// stale echo high before the start
					run_pulse($urandom_range(1, 60), $urandom_range(0, 10),
						$urandom_range(0, 3));
				else
					// raw noise on both request fields
					repeat ($urandom_range(5, 40))
						send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				runs++;
			end
			settle();
		end

		src_idle = 1'b0;
		sink_idle = 1'b0;
		settle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.pending_readings.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
